### hw/rtl/tem_pkg.sv
// Shared types and constants for the text extent measure block.
package tem_pkg;

    localparam int TableDepth = 256;
    localparam int IdxW = 8;
    localparam int FracBits = 4;

    localparam logic [15:0] CodeCr = 16'd13;
    localparam logic [15:0] CodeLf = 16'd10;
    localparam logic signed [31:0] S32Max = 32'sh7fffffff;

    typedef enum logic [1:0] {
        OP_LOAD   = 2'd0,
        OP_CHAR   = 2'd1,
        OP_FINISH = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        REG_LINE_SPACING = 3'd0,
        REG_GLYPH_COUNT  = 3'd1,
        REG_DEFAULT_IDX  = 3'd2,
        REG_DEFAULT_EN   = 3'd3,
        REG_ORIGIN_X     = 3'd4,
        REG_ORIGIN_Y     = 3'd5
    } t_reg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_FETCH,
        ST_UPDATE,
        ST_BOX,
        ST_OUT
    } t_state;

    // Glyph table entry as stored: code, sizes, offsets, advance.
    typedef struct packed {
        logic [15:0]        code;
        logic [11:0]        width;
        logic [11:0]        height;
        logic signed [15:0] offset_x;
        logic signed [15:0] offset_y;
        logic signed [15:0] advance_x;
    } t_glyph;

    // Write and read request from the control sequencer to the glyph memory.
    typedef struct packed {
        logic            wr_en;
        logic [IdxW-1:0] wr_addr;
        t_glyph          wr_data;
        logic [IdxW-1:0] rd_addr;
    } t_mem_req;

    function automatic logic signed [33:0] sat32(input logic signed [33:0] v);
        if (v > 34'sd2147483647) return 34'sd2147483647;
        if (v < -34'sd2147483648) return -34'sd2147483648;
        return v;
    endfunction

    function automatic logic signed [33:0] satext(input logic signed [33:0] v);
        if (v > 34'sd2147483647) return 34'sd2147483647;
        if (v < 34'sd0) return 34'sd0;
        return v;
    endfunction

    // Truncate toward zero to whole pixels.
    function automatic logic signed [33:0] to_pix(input logic signed [33:0] v);
        logic signed [33:0] a;
        a = (v < 0) ? -v : v;
        a = a >>> FracBits;
        return (v < 0) ? -a : a;
    endfunction

endpackage

### hw/rtl/tem_glyph_mem.sv
// Glyph table memory: one write port, one registered read port.
module tem_glyph_mem
    import tem_pkg::*;
(
    input  logic     i_clk,
    input  t_mem_req i_req,
    output t_glyph   o_rd_data
);

    t_glyph r_mem [TableDepth];

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        o_rd_data <= r_mem[i_req.rd_addr];
    end

endmodule

### hw/rtl/text_extent_measure.sv
// Top level of the text extent measure block.
// Loads a sorted glyph table one beat at a time, measures characters against it and,
// on a finish beat, emits the extent, the whole-pixel bounding box and a missing-glyph
// status, then clears the string state. One beat is in flight at a time: the input
// stalls until the current beat is done and the result register is empty. A load
// is written while idle; carriage return and newline pass through ST_SEARCH. A
// measured character issues a read and compares it per probe of the binary search
// over the single read port of the glyph memory (up to 9 probes for 256 entries),
// reads and checks the slot the search lands on, reads the default slot after a
// miss when it is enabled, then updates pen, extent and box in ST_UPDATE and ST_BOX
// and returns to idle. A finish beat passes through ST_OUT, which registers its result.
module text_extent_measure
    import tem_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_index,
    input  logic [23:0]        i_cfg_data,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [1:0]         i_operation,
    input  logic [7:0]         i_glyph_index,
    input  logic [15:0]        i_char_code,
    input  logic [11:0]        i_glyph_width,
    input  logic [11:0]        i_glyph_height,
    input  logic signed [15:0] i_offset_x,
    input  logic signed [15:0] i_offset_y,
    input  logic signed [15:0] i_advance_x,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [30:0]        o_extent_x,
    output logic [30:0]        o_extent_y,
    output logic signed [31:0] o_bound_left,
    output logic signed [31:0] o_bound_top,
    output logic signed [31:0] o_bound_right,
    output logic signed [31:0] o_bound_bottom,
    output logic               o_status
);

    logic [15:0]        r_line_spacing;
    logic [8:0]         r_glyph_count;
    logic [7:0]         r_default_idx;
    logic               r_default_en;
    logic signed [23:0] r_origin_x;
    logic signed [23:0] r_origin_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_spacing <= '0;
            r_glyph_count  <= '0;
            r_default_idx  <= '0;
            r_default_en   <= 1'b0;
            r_origin_x     <= '0;
            r_origin_y     <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_LINE_SPACING: r_line_spacing <= i_cfg_data[15:0];
                REG_GLYPH_COUNT:  r_glyph_count  <= i_cfg_data[8:0];
                REG_DEFAULT_IDX:  r_default_idx  <= i_cfg_data[7:0];
                REG_DEFAULT_EN:   r_default_en   <= i_cfg_data[0];
                REG_ORIGIN_X:     r_origin_x     <= i_cfg_data;
                REG_ORIGIN_Y:     r_origin_y     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    t_state r_state, n_state;
    logic   in_acc, out_acc;
    assign out_acc = o_valid && !i_stall;
    assign o_stall = (r_state != ST_IDLE) || o_valid;
    assign in_acc  = i_valid && !o_stall;

    // search state
    logic [8:0]  r_lo, r_n, r_count, r_mid;
    logic [15:0] r_key;
    logic        r_probe;   // read issued, data valid next cycle
    logic [8:0]  half, mid;
    logic        found;
    t_glyph      rd;
    t_mem_req    req;

    logic [8:0] cnt_clip;
    assign cnt_clip = (r_glyph_count > 9'd256) ? 9'd256 : r_glyph_count;
    assign half = r_n >> 1;
    assign mid  = r_lo + half;

    // per-string state
    logic signed [33:0] r_pen_x, r_pen_y, r_ext_x, r_ext_y;
    logic signed [33:0] r_bl, r_bt, r_br, r_bb;
    logic               r_missing;
    t_glyph             r_g;
    logic               r_counts;
    logic signed [33:0] r_minx, r_miny, r_maxx, r_maxy, r_tx, r_ty;

    always_comb begin
        req.wr_en   = in_acc && (t_op'(i_operation) == OP_LOAD);
        req.wr_addr = i_glyph_index;
        req.wr_data = '{code: i_char_code, width: i_glyph_width,
                        height: i_glyph_height, offset_x: i_offset_x,
                        offset_y: i_offset_y, advance_x: i_advance_x};
        // on a miss the default slot is read while the hit check runs
        req.rd_addr = (r_state == ST_FETCH) ? r_default_idx : mid[7:0];
    end

    tem_glyph_mem u_mem (.i_clk(i_clk), .i_req(req), .o_rd_data(rd));

    // probe compare for last issued read
    logic lt;
    assign lt = rd.code < r_key;
    assign found = (r_lo < r_count) && (rd.code == r_key);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    unique case (t_op'(i_operation))
                        OP_CHAR:   n_state = ST_SEARCH;
                        OP_FINISH: n_state = ST_OUT;
                        default:   n_state = ST_IDLE;
                    endcase
                end
            end
            ST_SEARCH: begin
                if (r_key == CodeCr || r_key == CodeLf) n_state = ST_IDLE;
                else if (!r_probe && r_n == 9'd0) n_state = ST_FETCH;
            end
            ST_FETCH: begin
                if (r_probe || found) n_state = ST_UPDATE;
                else if (!r_default_en) n_state = ST_IDLE;
            end
            ST_UPDATE: n_state = ST_BOX;
            ST_BOX:    n_state = ST_IDLE;
            ST_OUT:    n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_IDLE;
        else          r_state <= n_state;
    end

    logic signed [33:0] spacing, w16, h16, px, tmp;

    assign spacing = 34'(r_line_spacing);

    always_comb begin
        w16 = 34'(r_g.width) <<< FracBits;
        h16 = 34'(r_g.height) <<< FracBits;
        px = sat32(r_pen_x + 34'($signed(r_g.offset_x)));
        if (px < 0) px = '0;
        tmp = h16 + 34'($signed(r_g.offset_y));
        if (spacing > tmp) tmp = spacing;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_probe   <= 1'b0;
            o_valid   <= 1'b0;
            r_pen_x   <= '0;
            r_pen_y   <= '0;
            r_ext_x   <= '0;
            r_ext_y   <= '0;
            r_bl      <= 34'(S32Max);
            r_bt      <= 34'(S32Max);
            r_br      <= '0;
            r_bb      <= '0;
            r_missing <= 1'b0;
        end else begin
            if (out_acc) o_valid <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    r_probe <= 1'b0;
                    if (in_acc) begin
                        r_key   <= i_char_code;
                        r_lo    <= '0;
                        r_n     <= cnt_clip;
                        r_count <= cnt_clip;
                    end
                end
                ST_SEARCH: begin
                    if (r_key == CodeLf) begin
                        r_pen_x <= '0;
                        r_pen_y <= sat32(r_pen_y + spacing);
                    end else if (r_probe) begin
                        // evaluate probe at r_mid
                        r_probe <= 1'b0;
                        if (lt) begin
                            r_lo <= r_mid + 9'd1;
                            r_n  <= r_n - (r_n >> 1) - 9'd1;
                        end else begin
                            r_n <= r_n >> 1;
                        end
                    end else if (r_n != 9'd0) begin
                        r_mid   <= mid;
                        r_probe <= 1'b1;
                    end else begin
                        r_mid <= r_lo;
                    end
                end
                ST_FETCH: begin
                    // rd holds the slot at lo first, the default slot after a miss
                    if (r_probe || found) begin
                        r_g     <= rd;
                        r_probe <= 1'b0;
                    end else if (r_default_en) begin
                        r_probe <= 1'b1;
                    end else begin
                        r_missing <= 1'b1;
                    end
                end
                ST_UPDATE: begin
                    r_counts <= !((r_key >= 16'd9 && r_key <= 16'd13) || r_key == 16'd32)
                              || r_g.width > 12'd1 || r_g.height > 12'd1;
                    r_tx <= satext(px + w16);
                    r_ty <= satext(r_pen_y + tmp);
                    r_minx <= 34'(r_origin_x) + px;
                    r_miny <= 34'(r_origin_y) + r_pen_y + 34'($signed(r_g.offset_y));
                    r_maxx <= 34'(r_origin_x) + px + w16 +
                              (($signed(r_g.advance_x) > 0) ?
                               34'($signed(r_g.advance_x)) : 34'sd0);
                    r_maxy <= 34'(r_origin_y) + r_pen_y + 34'($signed(r_g.offset_y)) + h16;
                    r_pen_x <= sat32(px + w16 + 34'($signed(r_g.advance_x)));
                end
                ST_BOX: begin
                    if (r_counts) begin
                        if (r_tx > r_ext_x) r_ext_x <= r_tx;
                        if (r_ty > r_ext_y) r_ext_y <= r_ty;
                        if (sat32(to_pix(r_minx)) < r_bl) r_bl <= sat32(to_pix(r_minx));
                        if (sat32(to_pix(r_miny)) < r_bt) r_bt <= sat32(to_pix(r_miny));
                        if (sat32(to_pix(r_maxx)) > r_br) r_br <= sat32(to_pix(r_maxx));
                        if (sat32(to_pix(r_maxy)) > r_bb) r_bb <= sat32(to_pix(r_maxy));
                    end
                end
                ST_OUT: begin
                    o_valid        <= 1'b1;
                    o_extent_x     <= r_ext_x[30:0];
                    o_extent_y     <= r_ext_y[30:0];
                    o_bound_left   <= (r_bl == 34'(S32Max)) ? 32'sd0 : r_bl[31:0];
                    o_bound_top    <= (r_bl == 34'(S32Max)) ? 32'sd0 : r_bt[31:0];
                    o_bound_right  <= r_br[31:0];
                    o_bound_bottom <= r_bb[31:0];
                    o_status       <= r_missing;
                    r_pen_x   <= '0;
                    r_pen_y   <= '0;
                    r_ext_x   <= '0;
                    r_ext_y   <= '0;
                    r_bl      <= 34'(S32Max);
                    r_bt      <= 34'(S32Max);
                    r_br      <= '0;
                    r_bb      <= '0;
                    r_missing <= 1'b0;
                end
                default: ;
            endcase
        end
    end

    a_out_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(r_state) == ST_OUT) else $error("result without finish");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |-> r_state == ST_IDLE) else $error("accept while busy");
    a_ext_nonneg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ext_x >= 0 && r_ext_y >= 0) else $error("negative extent");

endmodule

### tb/tb_top.sv
// Self-checking testbench for text_extent_measure: glyph loads, measuring and extent results.
module tb_top;
    import tem_pkg::*;

    localparam int CycleLimit = 200000;
    localparam int SettleCycles = 40;
    localparam int HoldCycles = 300;
    localparam logic [2:0] RegBeyondList = 3'd7;
    localparam longint S32Hi = 64'sd2147483647;
    localparam longint S32Lo = -64'sd2147483648;

    typedef struct {
        t_op                op;
        logic [7:0]         idx;
        logic [15:0]        code;
        logic [11:0]        w;
        logic [11:0]        h;
        logic signed [15:0] ox;
        logic signed [15:0] oy;
        logic signed [15:0] adv;
    } t_beat;

    typedef struct {
        logic [30:0]        ext_x;
        logic [30:0]        ext_y;
        logic signed [31:0] left;
        logic signed [31:0] top;
        logic signed [31:0] right;
        logic signed [31:0] bottom;
        logic               status;
    } t_extent;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [2:0]         i_cfg_index;
    logic [23:0]        i_cfg_data;
    logic               i_valid;
    logic               o_stall;
    logic [1:0]         i_operation;
    logic [7:0]         i_glyph_index;
    logic [15:0]        i_char_code;
    logic [11:0]        i_glyph_width;
    logic [11:0]        i_glyph_height;
    logic signed [15:0] i_offset_x;
    logic signed [15:0] i_offset_y;
    logic signed [15:0] i_advance_x;
    logic               o_valid;
    logic               i_stall;
    logic [30:0]        o_extent_x;
    logic [30:0]        o_extent_y;
    logic signed [31:0] o_bound_left;
    logic signed [31:0] o_bound_top;
    logic signed [31:0] o_bound_right;
    logic signed [31:0] o_bound_bottom;
    logic               o_status;

    text_extent_measure dut (.*);

    // Predictor state: glyph table, configuration and per-string pen and box.
    logic [15:0]        font_code [TableDepth];
    logic [11:0]        font_w [TableDepth];
    logic [11:0]        font_h [TableDepth];
    logic signed [15:0] font_ox [TableDepth];
    logic signed [15:0] font_oy [TableDepth];
    logic signed [15:0] font_adv [TableDepth];
    bit                 font_loaded [TableDepth];

    int unsigned cfg_spacing, cfg_count, cfg_def_idx, cfg_def_en;
    longint      cfg_org_x, cfg_org_y;
    longint      pen_x, pen_y, ext_x, ext_y, box_l, box_t, box_r, box_b;
    bit          glyph_missing;

    t_extent pending_extents[$];
    int      mismatches;
    int      cycles;
    int      send_idle_pct;
    int      recv_stall_pct;
    int      hold_requests;
    int      hold_seen;
    int      hold_left;

    function automatic longint clamp(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic void clear_string();
        pen_x = 0;
        pen_y = 0;
        ext_x = 0;
        ext_y = 0;
        box_l = S32Hi;
        box_t = S32Hi;
        box_r = 0;
        box_b = 0;
        glyph_missing = 1'b0;
    endfunction

    function automatic void measure_char(logic [15:0] code);
        int unsigned cnt, lo, n, half, mid, slot;
        longint w, h, ox, oy, adv, gw, gh, t, mnx, mny, mxx, mxy;
        bit ws;
        cnt = cfg_count > TableDepth ? TableDepth : cfg_count;
        if (code == CodeCr) return;
        if (code == CodeLf) begin
            pen_x = 0;
            pen_y = clamp(pen_y + longint'(cfg_spacing), S32Lo, S32Hi);
            return;
        end
        lo = 0;
        n = cnt;
        while (n > 0) begin
            half = n / 2;
            mid = lo + half;
            if (font_code[mid] < code) begin
                lo = mid + 1;
                n -= half + 1;
            end else begin
                n = half;
            end
        end
        if (lo < cnt && font_code[lo] == code) begin
            slot = lo;
        end else if (cfg_def_en != 0) begin
            slot = cfg_def_idx;
        end else begin
            glyph_missing = 1'b1;
            return;
        end
        w = longint'(font_w[slot]);
        h = longint'(font_h[slot]);
        ox = longint'(font_ox[slot]);
        oy = longint'(font_oy[slot]);
        adv = longint'(font_adv[slot]);
        gw = w * (1 << FracBits);
        gh = h * (1 << FracBits);
        pen_x = clamp(pen_x + ox, S32Lo, S32Hi);
        if (pen_x < 0) pen_x = 0;
        ws = (code >= 9 && code <= 13) || code == 32;
        if (!ws || w > 1 || h > 1) begin
            t = clamp(pen_x + gw, 0, S32Hi);
            if (t > ext_x) ext_x = t;
            t = gh + oy;
            if (longint'(cfg_spacing) > t) t = longint'(cfg_spacing);
            t = clamp(pen_y + t, 0, S32Hi);
            if (t > ext_y) ext_y = t;
            mnx = cfg_org_x + pen_x;
            mny = cfg_org_y + pen_y + oy;
            mxx = mnx + gw + (adv > 0 ? adv : 0);
            mxy = mny + gh;
            // truncate toward zero to whole pixels
            mnx = clamp(mnx / (1 << FracBits), S32Lo, S32Hi);
            mny = clamp(mny / (1 << FracBits), S32Lo, S32Hi);
            mxx = clamp(mxx / (1 << FracBits), S32Lo, S32Hi);
            mxy = clamp(mxy / (1 << FracBits), S32Lo, S32Hi);
            if (mnx < box_l) box_l = mnx;
            if (mny < box_t) box_t = mny;
            if (mxx > box_r) box_r = mxx;
            if (mxy > box_b) box_b = mxy;
        end
        pen_x = clamp(pen_x + gw + adv, S32Lo, S32Hi);
    endfunction

    function automatic void predict_beat(t_beat b);
        t_extent e;
        case (b.op)
            OP_LOAD: begin
                font_code[b.idx] = b.code;
                font_w[b.idx] = b.w;
                font_h[b.idx] = b.h;
                font_ox[b.idx] = b.ox;
                font_oy[b.idx] = b.oy;
                font_adv[b.idx] = b.adv;
                font_loaded[b.idx] = 1'b1;
            end
            OP_CHAR: measure_char(b.code);
            OP_FINISH: begin
                e.ext_x = ext_x[30:0];
                e.ext_y = ext_y[30:0];
                e.left = (box_l == S32Hi) ? 32'sd0 : box_l[31:0];
                e.top = (box_l == S32Hi) ? 32'sd0 : box_t[31:0];
                e.right = box_r[31:0];
                e.bottom = box_b[31:0];
                e.status = glyph_missing;
                pending_extents.push_back(e);
                clear_string();
            end
            default: ;
        endcase
    endfunction

    function automatic t_beat rand_beat(t_op op);
        t_beat b;
        b.op = op;
        b.idx = 8'($urandom);
        b.code = 16'($urandom);
        b.w = 12'($urandom);
        b.h = 12'($urandom);
        b.ox = 16'($urandom);
        b.oy = 16'($urandom);
        b.adv = 16'($urandom);
        return b;
    endfunction

    function automatic t_beat glyph(int slot, int code, int w, int h, int ox, int oy, int adv);
        t_beat b;
        b = rand_beat(OP_LOAD);
        b.idx = 8'(slot);
        b.code = 16'(code);
        b.w = 12'(w);
        b.h = 12'(h);
        b.ox = 16'(ox);
        b.oy = 16'(oy);
        b.adv = 16'(adv);
        return b;
    endfunction

    function automatic t_beat char_beat(int code);
        t_beat b;
        b = rand_beat(OP_CHAR);
        b.code = 16'(code);
        return b;
    endfunction

    // Drive one beat, hold it until accepted, then maybe go idle a while.
    task automatic send_beat(t_beat b);
        i_valid <= 1'b1;
        i_operation <= b.op;
        i_glyph_index <= b.idx;
        i_char_code <= b.code;
        i_glyph_width <= b.w;
        i_glyph_height <= b.h;
        i_offset_x <= b.ox;
        i_offset_y <= b.oy;
        i_advance_x <= b.adv;
        do @(posedge i_clk); while (o_stall);
        predict_beat(b);
        if ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    task automatic wait_idle();
        i_valid <= 1'b0;
        while (pending_extents.size() != 0) @(posedge i_clk);
        repeat (SettleCycles) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] index, logic [23:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (index)
            REG_LINE_SPACING: cfg_spacing = 32'(data[15:0]);
            REG_GLYPH_COUNT:  cfg_count = 32'(data[8:0]);
            REG_DEFAULT_IDX:  cfg_def_idx = 32'(data[7:0]);
            REG_DEFAULT_EN:   cfg_def_en = 32'(data[0]);
            REG_ORIGIN_X:     cfg_org_x = longint'($signed(data));
            REG_ORIGIN_Y:     cfg_org_y = longint'($signed(data));
            default: ;
        endcase
    endtask

    task automatic set_idling(int mode);
        case (mode)
            0: begin send_idle_pct = 0; recv_stall_pct = 0; end
            1: begin send_idle_pct = 59; recv_stall_pct = 0; end
            2: begin send_idle_pct = 0; recv_stall_pct = 59; end
            default: begin send_idle_pct = 14; recv_stall_pct = 14; end
        endcase
    endtask

    task automatic test_directed();
        wait_idle();
        write_reg(REG_LINE_SPACING, 24'd320);
        write_reg(REG_GLYPH_COUNT, 24'd5);
        write_reg(REG_DEFAULT_IDX, 24'd2);
        write_reg(REG_DEFAULT_EN, 24'd0);
        write_reg(REG_ORIGIN_X, 24'd0);
        write_reg(REG_ORIGIN_Y, 24'd0);
        write_reg(RegBeyondList, 24'hffffff);
        send_beat(glyph(0, 9, 1, 1, 0, 0, 0));
        send_beat(glyph(1, 32, 0, 0, 4, 0, 16));
        send_beat(glyph(2, 65, 8, 12, 16, -32, 8));
        send_beat(glyph(3, 66, 4095, 4095, 32767, 32767, 32767));
        send_beat(glyph(4, 16'hffff, 3, 5, -32768, -32768, -32768));
        send_beat(rand_beat(OP_FINISH));    // empty string
        send_beat(char_beat(65));
        send_beat(char_beat(9));
        send_beat(char_beat(32));
        send_beat(char_beat(CodeCr));
        send_beat(char_beat(CodeLf));
        send_beat(char_beat(66));
        send_beat(char_beat(16'hffff));
        send_beat(char_beat(100));          // no glyph, no default
        send_beat(rand_beat(OP_FINISH));
        wait_idle();
        write_reg(REG_DEFAULT_EN, 24'd1);
        write_reg(REG_ORIGIN_X, 24'h800000);
        write_reg(REG_ORIGIN_Y, 24'h800000);
        send_beat(char_beat(100));
        send_beat(char_beat(0));
        send_beat(rand_beat(OP_NONE));
        send_beat(glyph(1, 200, 2, 2, 0, 0, 0)); // break the sort order
        send_beat(char_beat(200));
        send_beat(char_beat(65));
        send_beat(rand_beat(OP_FINISH));
        wait_idle();
        write_reg(REG_GLYPH_COUNT, 24'd0);
        write_reg(REG_LINE_SPACING, 24'd65535);
        write_reg(REG_ORIGIN_X, 24'h7fffff);
        write_reg(REG_ORIGIN_Y, 24'h7fffff);
        send_beat(char_beat(CodeLf));
        send_beat(char_beat(66));
        send_beat(rand_beat(OP_FINISH));
        wait_idle();
    endtask

    task automatic test_random_tables();
        int size, code, d, pick;
        t_beat b;
        for (int ph = 0; ph < 8; ph++) begin
            set_idling(ph % 4);
            size = (ph == 1) ? TableDepth : $urandom_range(1, 12);
            code = $urandom_range(0, 40);
            for (int s = 0; s < size; s++) begin
                b = rand_beat(OP_LOAD);
                b.idx = 8'(s);
                b.code = 16'(code);
                if ($urandom_range(3) != 0) begin
                    b.w = 12'($urandom_range(0, 20));
                    b.h = 12'($urandom_range(0, 20));
                    b.ox = 16'(int'($urandom_range(0, 64)) - 32);
                    b.oy = 16'(int'($urandom_range(0, 256)) - 128);
                    b.adv = 16'(int'($urandom_range(0, 64)) - 16);
                end
                send_beat(b);
                code += (size == TableDepth) ? $urandom_range(1, 200) : $urandom_range(1, 3000);
            end
            wait_idle();
            if (ph == 1) write_reg(REG_GLYPH_COUNT, 24'd511);
            else if (ph == 5) write_reg(REG_GLYPH_COUNT, 24'd256);
            else write_reg(REG_GLYPH_COUNT, 24'(size));
            do d = $urandom_range(0, TableDepth - 1); while (!font_loaded[d]);
            write_reg(REG_DEFAULT_IDX, 24'(d));
            write_reg(REG_DEFAULT_EN, 24'($urandom_range(1)));
            write_reg(REG_LINE_SPACING, (ph == 3) ? 24'd65535 : 24'($urandom_range(0, 400)));
            write_reg(REG_ORIGIN_X, (ph == 6) ? 24'h800000 : 24'($urandom));
            write_reg(REG_ORIGIN_Y, (ph == 6) ? 24'h7fffff : 24'($urandom));
            repeat (4) begin
                repeat ($urandom_range(0, 6)) begin
                    pick = $urandom_range(99);
                    if (pick < 60) begin
                        send_beat(char_beat(int'(font_code[$urandom_range(0,
                            (cfg_count > size ? TableDepth : size) - 1)])));
                    end else if (pick < 70) begin
                        send_beat(char_beat(CodeLf));
                    end else if (pick < 75) begin
                        send_beat(char_beat(CodeCr));
                    end else if (pick < 80) begin
                        send_beat(char_beat($urandom_range(1) ? 32 : $urandom_range(9, 13)));
                    end else if (pick < 95) begin
                        send_beat(char_beat($urandom));
                    end else begin
                        send_beat(rand_beat(OP_NONE));
                    end
                end
                send_beat(rand_beat(OP_FINISH));
            end
            wait_idle();
        end
    endtask

    // Hold the output off while finishes pile up so the block stalls its input.
    task automatic test_backpressure();
        set_idling(0);
        hold_requests++;
        repeat (6) begin
            send_beat(char_beat($urandom));
            send_beat(rand_beat(OP_FINISH));
        end
        wait_idle();
    endtask

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (hold_requests != hold_seen) begin
            hold_seen <= hold_requests;
            hold_left <= HoldCycles - 1;
            i_stall <= 1'b1;
        end else if (hold_left > 0) begin
            i_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end else begin
            i_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %h, got %h", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_extent e;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_extents.size() == 0) begin
                $error("result beat with none expected");
                mismatches++;
            end else begin
                e = pending_extents.pop_front();
                check_field("extent_x", 32'(e.ext_x), 32'(o_extent_x));
                check_field("extent_y", 32'(e.ext_y), 32'(o_extent_y));
                check_field("bound_left", e.left, o_bound_left);
                check_field("bound_top", e.top, o_bound_top);
                check_field("bound_right", e.right, o_bound_right);
                check_field("bound_bottom", e.bottom, o_bound_bottom);
                check_field("status", 32'(e.status), 32'(o_status));
            end
        end
    end

    initial begin
        set_idling(0);
        cfg_spacing = 0;
        cfg_count = 0;
        cfg_def_idx = 0;
        cfg_def_en = 0;
        cfg_org_x = 0;
        cfg_org_y = 0;
        foreach (font_loaded[k]) font_loaded[k] = 1'b0;
        clear_string();
        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data <= '0;
        i_valid <= 1'b0;
        i_operation <= OP_NONE;
        i_glyph_index <= '0;
        i_char_code <= '0;
        i_glyph_width <= '0;
        i_glyph_height <= '0;
        i_offset_x <= '0;
        i_offset_y <= '0;
        i_advance_x <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_backpressure();
        test_random_tables();
        wait_idle();
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

### text_extent_measure.f
hw/rtl/tem_pkg.sv
hw/rtl/tem_glyph_mem.sv
hw/rtl/text_extent_measure.sv
tb/tb_top.sv
